// ----- hw/rtl/rrsg_pkg.sv -----
// ----------------------------------------------------------------------------
// rrsg_pkg
// shared widths, fill select codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rrsg_pkg;

  localparam int MAX_RADIUS    = 8;
  localparam int SCREEN_EXTENT = 4096;

  localparam int IN_W    = $clog2(SCREEN_EXTENT);
  localparam int COORD_W = IN_W + 1;
  localparam int SIZE_W  = IN_W;
  localparam int RAD_W   = 4;
  localparam int STEP_W  = RAD_W + 2;
  localparam int DEC_W   = RAD_W + 4;

  // which fill the datapath presents to the output register
  localparam logic [2:0] FILL_PLAIN  = 3'd0;
  localparam logic [2:0] FILL_HBAND  = 3'd1;
  localparam logic [2:0] FILL_VBAND  = 3'd2;
  localparam logic [2:0] FILL_SPAN_A = 3'd3;
  localparam logic [2:0] FILL_SPAN_B = 3'd4;

  typedef struct packed {
    logic       load;
    logic       init_corner;
    logic       corner_first;
    logic       step;
    logic       out_load;
    logic [2:0] fill_sel;
    logic       last;
  } rrsg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic radius_zero;
    logic last_step;
    logic last_corner;
  } rrsg_status_t;

endpackage

// ----- hw/rtl/rrsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrsg_ctrl
// sequencer: plain fill, or two bands then four midpoint-traced corners
// ----------------------------------------------------------------------------
module rrsg_ctrl
  import rrsg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  rrsg_status_t status,
  output rrsg_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PLAIN  = 3'd1;
  localparam logic [2:0] ST_HBAND  = 3'd2;
  localparam logic [2:0] ST_VBAND  = 3'd3;
  localparam logic [2:0] ST_SPAN_A = 3'd4;
  localparam logic [2:0] ST_SPAN_B = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.fill_sel     = FILL_PLAIN;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.radius_zero ? ST_PLAIN : ST_HBAND;
        end
      end
      ST_PLAIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.fill_sel = FILL_PLAIN;
          cmd.last     = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_HBAND: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.fill_sel = FILL_HBAND;
          state_next   = ST_VBAND;
        end
      end
      ST_VBAND: begin
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.fill_sel     = FILL_VBAND;
          cmd.init_corner  = 1'b1;
          cmd.corner_first = 1'b1;
          state_next       = ST_SPAN_A;
        end
      end
      ST_SPAN_A: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.fill_sel = FILL_SPAN_A;
          state_next   = ST_SPAN_B;
        end
      end
      ST_SPAN_B: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.fill_sel = FILL_SPAN_B;
          cmd.step     = 1'b1;
          state_next   = ST_SPAN_A;
          if (status.last_step) begin
            if (status.last_corner) begin
              cmd.last   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cmd.init_corner = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/rrsg_datapath.sv -----
// ----------------------------------------------------------------------------
// rrsg_datapath
// rectangle registers, radius clamp, midpoint stepper and output register
// ----------------------------------------------------------------------------
module rrsg_datapath
  import rrsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rrsg_cmd_t           cmd,
  output rrsg_status_t        status,
  input  logic [IN_W-1:0]     rect_x,
  input  logic [IN_W-1:0]     rect_y,
  input  logic [IN_W-1:0]     rect_width,
  input  logic [IN_W-1:0]     rect_height,
  input  logic [RAD_W-1:0]    corner_radius,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COORD_W-1:0]  fill_x,
  output logic [COORD_W-1:0]  fill_y,
  output logic [SIZE_W-1:0]   fill_width,
  output logic [SIZE_W-1:0]   fill_height,
  output logic                last_of_run
);

  logic [IN_W-1:0]  x;
  logic [IN_W-1:0]  y;
  logic [IN_W-1:0]  w;
  logic [IN_W-1:0]  h;
  logic [RAD_W-1:0] r;

  logic signed [STEP_W-1:0] px;
  logic signed [STEP_W-1:0] py;
  logic signed [DEC_W-1:0]  d;
  logic [1:0]               corner;

  // radius clamp at load
  logic [RAD_W-1:0] r_sat;
  logic [RAD_W-1:0] r_wclamp;
  logic [RAD_W-1:0] r_clamp;
  logic [IN_W-1:0]  half_w;
  logic [IN_W-1:0]  half_h;

  assign half_w = rect_width >> 1;
  assign half_h = rect_height >> 1;

  always_comb begin
    r_sat    = (corner_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : corner_radius;
    r_wclamp = (IN_W'(r_sat) > half_w) ? RAD_W'(half_w) : r_sat;
    r_clamp  = (IN_W'(r_wclamp) > half_h) ? RAD_W'(half_h) : r_wclamp;
  end

  // midpoint step
  logic signed [STEP_W-1:0] px_next;
  logic signed [STEP_W-1:0] py_next;
  logic signed [DEC_W-1:0]  d_next;
  logic signed [DEC_W-1:0]  px_ext;
  logic signed [DEC_W-1:0]  diff_ext;

  always_comb begin
    px_next  = px + STEP_W'(1);
    py_next  = d[DEC_W-1] ? py : (py - STEP_W'(1));
    px_ext   = {{(DEC_W-STEP_W){px_next[STEP_W-1]}}, px_next};
    diff_ext = px_ext - {{(DEC_W-STEP_W){py_next[STEP_W-1]}}, py_next};
    if (d[DEC_W-1]) begin
      d_next = d + (px_ext <<< 1) + DEC_W'(1);
    end else begin
      d_next = d + (diff_ext <<< 1) + DEC_W'(1);
    end
  end

  // corner centre
  logic                left_side;
  logic                up;
  logic [COORD_W-1:0]  x13;
  logic [COORD_W-1:0]  y13;
  logic [COORD_W-1:0]  r13;
  logic [COORD_W-1:0]  cx;
  logic [COORD_W-1:0]  cy;
  logic [COORD_W-1:0]  px13;
  logic [COORD_W-1:0]  py13;

  assign left_side = ~corner[0];
  assign up        = ~corner[1];
  assign x13       = COORD_W'(x);
  assign y13       = COORD_W'(y);
  assign r13       = COORD_W'(r);
  assign px13      = COORD_W'(px[RAD_W-1:0]);
  assign py13      = COORD_W'(py[RAD_W-1:0]);

  always_comb begin
    cx = left_side ? (x13 + r13) : (x13 + COORD_W'(w) - r13 - COORD_W'(1));
    cy = up ? (y13 + r13) : (y13 + COORD_W'(h) - r13 - COORD_W'(1));
  end

  // fill selection
  logic [COORD_W-1:0] sel_x;
  logic [COORD_W-1:0] sel_y;
  logic [SIZE_W-1:0]  sel_w;
  logic [SIZE_W-1:0]  sel_h;
  logic [SIZE_W-1:0]  r2;

  assign r2 = SIZE_W'(r) << 1;

  always_comb begin
    case (cmd.fill_sel)
      FILL_HBAND: begin
        sel_x = x13 + r13;
        sel_y = y13;
        sel_w = w - r2;
        sel_h = h;
      end
      FILL_VBAND: begin
        sel_x = x13;
        sel_y = y13 + r13;
        sel_w = w;
        sel_h = h - r2;
      end
      FILL_SPAN_A: begin
        sel_x = left_side ? (cx - py13) : cx;
        sel_y = up ? (cy - px13) : (cy + px13);
        sel_w = SIZE_W'(py[RAD_W-1:0]) + SIZE_W'(1);
        sel_h = SIZE_W'(1);
      end
      FILL_SPAN_B: begin
        sel_x = left_side ? (cx - px13) : cx;
        sel_y = up ? (cy - py13) : (cy + py13);
        sel_w = SIZE_W'(px[RAD_W-1:0]) + SIZE_W'(1);
        sel_h = SIZE_W'(1);
      end
      default: begin
        sel_x = x13;
        sel_y = y13;
        sel_w = w;
        sel_h = h;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= rect_x;
      y <= rect_y;
      w <= rect_width;
      h <= rect_height;
      r <= r_clamp;
    end
    if (cmd.init_corner) begin
      px     <= '0;
      py     <= STEP_W'(r);
      d      <= DEC_W'(1) - DEC_W'(r);
      corner <= cmd.corner_first ? 2'd0 : (corner + 2'd1);
    end else if (cmd.step) begin
      px <= px_next;
      py <= py_next;
      d  <= d_next;
    end
    if (cmd.out_load) begin
      fill_x      <= sel_x;
      fill_y      <= sel_y;
      fill_width  <= sel_w;
      fill_height <= sel_h;
      last_of_run <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free    = ~out_valid | ~out_stall;
  assign status.radius_zero = (corner_radius == '0);
  assign status.last_step   = (px_next > py_next);
  assign status.last_corner = (corner == 2'd3);

endmodule

// ----- hw/rtl/rounded_rect_span_generator_unit.sv -----
// ----------------------------------------------------------------------------
// rounded_rect_span_generator_unit
// turns one rectangle and corner radius into the fills of a rounded rectangle
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  -----------------------------------
//  in       sink       in_valid / in_stall  rect_x, rect_y, rect_width,
//                                           rect_height, corner_radius
//  out      source     out_valid/out_stall  fill_x, fill_y, fill_width,
//                                           fill_height, last_of_run
//
// a transaction is taken in the idle state, then one fill per cycle while the output
// register is free: 1 fill at radius zero, otherwise 2 bands plus 8 spans per midpoint
// step, 50 fills at radius 8; the controller sequencer emits the fills
// in_stall is low only while the sequencer is idle and stays high until the last fill
// is loaded into the output register; the next rectangle can enter while that fill waits
// out_stall holds the output register and freezes the sequencer in place
// rst is synchronous and clears the sequencer state and the output valid flag
//
module rounded_rect_span_generator_unit
  import rrsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input transaction
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [IN_W-1:0]     rect_x,
  input  logic [IN_W-1:0]     rect_y,
  input  logic [IN_W-1:0]     rect_width,
  input  logic [IN_W-1:0]     rect_height,
  input  logic [RAD_W-1:0]    corner_radius,
  // output transaction
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COORD_W-1:0]  fill_x,
  output logic [COORD_W-1:0]  fill_y,
  output logic [SIZE_W-1:0]   fill_width,
  output logic [SIZE_W-1:0]   fill_height,
  output logic                last_of_run
);

  // commands from the sequencer, status back from the datapath
  rrsg_cmd_t    cmd;
  rrsg_status_t status;

  // sequencer: idle, plain fill, two bands, then span pairs per corner
  rrsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: clamp, corner centres, midpoint stepper, output register
  rrsg_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rect_x        (rect_x),
    .rect_y        (rect_y),
    .rect_width    (rect_width),
    .rect_height   (rect_height),
    .corner_radius (corner_radius),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fill_x        (fill_x),
    .fill_y        (fill_y),
    .fill_width    (fill_width),
    .fill_height   (fill_height),
    .last_of_run   (last_of_run)
  );

endmodule
